@@ rtl/core/rdc_pkg.sv @@
// rdc_pkg: shared constants, types and tables of the radix digit conversion unit.
// Used by rdc_ctrl, rdc_datapath and radix_digit_conversion_unit; no dependencies.
package rdc_pkg;

  localparam int IN_DIGITS  = 8;
  localparam int OUT_DIGITS = 19;

  localparam int SRC_W   = 27;
  localparam int VAL_W   = 27;
  localparam int DIG_W   = 4;
  localparam int RES_W   = 64;
  localparam int BASE_W  = 4;
  localparam int TDATA_IN_W = 32;
  localparam int CNT_W   = $clog2(OUT_DIGITS + 1);
  localparam int PROD_W  = 2 * VAL_W;

  // src / 10 = (src * DIV10_M) >> DIV10_SH, exact for 32-bit src
  localparam logic [31:0] DIV10_M  = 32'hCCCC_CCCD;
  localparam int          DIV10_SH = 35;
  localparam int          P10_W    = SRC_W + 32;

  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd10;
  localparam logic [BASE_W-1:0] BASE_FROM_RST = 4'd10;
  localparam logic [BASE_W-1:0] BASE_TO_RST   = 4'd2;

  localparam logic REG_BASE_FROM = 1'b0;
  localparam logic REG_BASE_TO   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXTRACT,
    S_HORNER,
    S_MUL,
    S_FIX,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic extract;
    logic horner;
    logic out_init;
    logic mul;
    logic acc;
    logic fix;
    logic cnt_clr;
    logic cnt_inc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cnt_in_last;
    logic cnt_out_done;
    logic bad;
    logic v_zero;
    logic out_free;
  } status_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // floor(2^VAL_W / b); quotient estimate is low by at most one
  function automatic logic [VAL_W-1:0] recip_of(input logic [BASE_W-1:0] b);
    logic [VAL_W-1:0] r;
    case (b)
      4'd2:    r = 27'd67108864;
      4'd3:    r = 27'd44739242;
      4'd4:    r = 27'd33554432;
      4'd5:    r = 27'd26843545;
      4'd6:    r = 27'd22369621;
      4'd7:    r = 27'd19173961;
      4'd8:    r = 27'd16777216;
      4'd9:    r = 27'd14913080;
      default: r = 27'd13421772;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/rdc_ctrl.sv @@
// rdc_ctrl: sequencer of the radix digit conversion unit.
// Issues rdc_pkg::cmd_t to rdc_datapath and reads back rdc_pkg::status_t.
module rdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rdc_pkg::status_t status,
  output rdc_pkg::cmd_t    cmd
);

  rdc_pkg::state_t state;
  rdc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rdc_pkg::S_IDLE: begin
        if (in_valid) state_next = rdc_pkg::S_EXTRACT;
      end
      rdc_pkg::S_EXTRACT: begin
        if (status.cnt_in_last) state_next = rdc_pkg::S_HORNER;
      end
      rdc_pkg::S_HORNER: begin
        if (status.bad) begin
          state_next = rdc_pkg::S_DONE;
        end else if (status.cnt_in_last) begin
          state_next = rdc_pkg::S_MUL;
        end
      end
      rdc_pkg::S_MUL: begin
        if (status.v_zero || status.cnt_out_done) begin
          state_next = rdc_pkg::S_DONE;
        end else begin
          state_next = rdc_pkg::S_FIX;
        end
      end
      rdc_pkg::S_FIX: begin
        state_next = rdc_pkg::S_MUL;
      end
      rdc_pkg::S_DONE: begin
        if (status.out_free) state_next = rdc_pkg::S_IDLE;
      end
      default: state_next = rdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      rdc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rdc_pkg::S_EXTRACT: begin
        cmd.extract = 1'b1;
        cmd.cnt_inc = !status.cnt_in_last;
        cmd.cnt_clr = status.cnt_in_last;
      end
      rdc_pkg::S_HORNER: begin
        if (!status.bad) begin
          cmd.horner   = 1'b1;
          cmd.cnt_inc  = !status.cnt_in_last;
          cmd.cnt_clr  = status.cnt_in_last;
          cmd.out_init = status.cnt_in_last;
        end
      end
      rdc_pkg::S_MUL: begin
        cmd.acc = 1'b1;
        cmd.mul = !(status.v_zero || status.cnt_out_done);
      end
      rdc_pkg::S_FIX: begin
        cmd.fix     = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      rdc_pkg::S_DONE: begin
        cmd.emit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/rdc_datapath.sv @@
// rdc_datapath: base registers, digit extraction, Horner accumulation,
// reciprocal division by the output base and the output register. Uses rdc_pkg.
module rdc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [rdc_pkg::BASE_W-1:0]       cfg_wdata,
  input  logic [rdc_pkg::SRC_W-1:0]        src_in,
  input  rdc_pkg::cmd_t                    cmd,
  output rdc_pkg::status_t                 status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rdc_pkg::RES_W-1:0]        out_digits,
  output logic                             out_digit_error,
  output logic                             out_overflow
);

  logic [rdc_pkg::BASE_W-1:0] base_from;
  logic [rdc_pkg::BASE_W-1:0] base_to;
  logic [rdc_pkg::BASE_W-1:0] bf;
  logic [rdc_pkg::BASE_W-1:0] bt;
  logic [rdc_pkg::VAL_W-1:0]  recip;

  logic [rdc_pkg::SRC_W-1:0]  src;
  logic [rdc_pkg::IN_DIGITS-1:0][rdc_pkg::DIG_W-1:0] dig;
  logic                       bad;
  logic [rdc_pkg::CNT_W-1:0]  cnt;
  logic [rdc_pkg::VAL_W-1:0]  v;
  logic [rdc_pkg::PROD_W-1:0] prod;
  logic [rdc_pkg::DIG_W-1:0]  rdig;
  logic                       pend;
  logic [rdc_pkg::RES_W-1:0]  result;
  logic [rdc_pkg::RES_W-1:0]  place;

  logic [rdc_pkg::P10_W-1:0]  p10;
  logic [rdc_pkg::SRC_W-1:0]  q10;
  logic [rdc_pkg::SRC_W-1:0]  r10_full;
  logic [rdc_pkg::DIG_W-1:0]  d10;
  logic [rdc_pkg::VAL_W-1:0]  q_est;
  logic [rdc_pkg::VAL_W-1:0]  r_full;
  logic [rdc_pkg::VAL_W-1:0]  q_fix;
  logic [rdc_pkg::DIG_W-1:0]  r_fix;
  logic                       bad_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_from <= rdc_pkg::BASE_FROM_RST;
      base_to   <= rdc_pkg::BASE_TO_RST;
    end else if (cfg_we) begin
      if (cfg_index == rdc_pkg::REG_BASE_FROM) begin
        base_from <= cfg_wdata;
      end else begin
        base_to <= cfg_wdata;
      end
    end
  end

  // decimal digit split of the input: one digit per cycle
  always_comb begin
    p10      = rdc_pkg::P10_W'(src) * rdc_pkg::P10_W'(rdc_pkg::DIV10_M);
    q10      = rdc_pkg::SRC_W'(p10 >> rdc_pkg::DIV10_SH);
    r10_full = src - ((q10 << 3) + (q10 << 1));
    d10      = r10_full[rdc_pkg::DIG_W-1:0];
  end

  // quotient estimate from the registered product, then one correction
  always_comb begin
    q_est  = rdc_pkg::VAL_W'(prod >> rdc_pkg::VAL_W);
    r_full = v - rdc_pkg::VAL_W'(q_est * rdc_pkg::VAL_W'(bt));
    if (r_full >= rdc_pkg::VAL_W'(bt)) begin
      q_fix = q_est + 1'b1;
      r_fix = rdc_pkg::DIG_W'(r_full - rdc_pkg::VAL_W'(bt));
    end else begin
      q_fix = q_est;
      r_fix = r_full[rdc_pkg::DIG_W-1:0];
    end
  end

  assign recip   = rdc_pkg::recip_of(bt);
  assign bad_any = bad || (src != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src <= src_in;
      bf  <= rdc_pkg::clamp_base(base_from);
      bt  <= rdc_pkg::clamp_base(base_to);
      bad <= 1'b0;
      v   <= '0;
    end
    if (cmd.extract) begin
      src <= q10;
      dig <= {d10, dig[rdc_pkg::IN_DIGITS-1:1]};
      if (d10 >= bf) bad <= 1'b1;
    end
    if (cmd.horner) begin
      v   <= rdc_pkg::VAL_W'(v * rdc_pkg::VAL_W'(bf)) +
             rdc_pkg::VAL_W'(dig[rdc_pkg::IN_DIGITS-1]);
      dig <= {dig[rdc_pkg::IN_DIGITS-2:0], rdc_pkg::DIG_W'(0)};
    end
    if (cmd.out_init) begin
      result <= '0;
      place  <= rdc_pkg::RES_W'(1);
      pend   <= 1'b0;
    end
    if (cmd.acc && pend) begin
      result <= result + place * rdc_pkg::RES_W'(rdig);
      place  <= (place << 3) + (place << 1);
      pend   <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= rdc_pkg::PROD_W'(v) * rdc_pkg::PROD_W'(recip);
    end
    if (cmd.fix) begin
      v    <= q_fix;
      rdig <= r_fix;
      pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_digit_error <= bad_any;
      out_overflow    <= !bad_any && (v != '0);
      out_digits      <= (bad_any || (v != '0)) ? '0 : result;
    end
  end

  assign status.cnt_in_last  = (cnt == rdc_pkg::CNT_W'(rdc_pkg::IN_DIGITS - 1));
  assign status.cnt_out_done = (cnt == rdc_pkg::CNT_W'(rdc_pkg::OUT_DIGITS));
  assign status.bad          = bad_any;
  assign status.v_zero       = (v == '0);
  assign status.out_free     = !out_valid || out_ready;

endmodule

@@ rtl/core/radix_digit_conversion_unit.sv @@
// radix_digit_conversion_unit: top level of the radix digit conversion unit.
// Instantiates rdc_ctrl and rdc_datapath; uses rdc_pkg.
//
// Takes a number whose decimal digits are base_from digits and returns the
// same value with decimal digits in base_to. One item is processed at a time:
// the input is split into its 8 decimal digits, the value is accumulated
// in binary, then each output digit takes a reciprocal multiply and a
// correction step, then a closing step and the output handshake.
// A bad digit ends the item before accumulation, with digit_error set and zero
// data. More than 19 output digits set overflow with zero data. Bases outside
// 2..10 are clamped. The output register holds a result while the next item
// is accepted.
module radix_digit_conversion_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [26:0] digits_in, [31:27] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [63:0] digits_out
  output logic [1:0]  m_tuser     // [0] digit_error, [1] overflow
);

  rdc_pkg::cmd_t    cmd;
  rdc_pkg::status_t status;
  logic             digit_error;
  logic             overflow;

  rdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rdc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .src_in          (s_tdata[rdc_pkg::SRC_W-1:0]),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_digits      (m_tdata),
    .out_digit_error (digit_error),
    .out_overflow    (overflow)
  );

  assign m_tuser = {overflow, digit_error};

endmodule
